FILE: rtl/aeske_pkg.sv
// Shared types, constants and lookup functions for the AES-128 key expansion block.
package aeske_pkg;

	localparam int KeyWords   = 4;
	localparam int SchedWords = 44;
	localparam int IdxW       = 6;
	localparam int WordW      = 32;
	localparam int OutDataW   = 40;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(SchedWords - 1);

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic load;
		logic advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic word_t sub_word(input word_t w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic word_t rot_word(input word_t w);
		rot_word = {w[23:0], w[31:24]};
	endfunction

	// Round constant in the first byte; rounds past ten never reach the output.
	function automatic word_t rcon(input logic [3:0] rnd);
		case (rnd)
			4'd0:    rcon = 32'h0100_0000;
			4'd1:    rcon = 32'h0200_0000;
			4'd2:    rcon = 32'h0400_0000;
			4'd3:    rcon = 32'h0800_0000;
			4'd4:    rcon = 32'h1000_0000;
			4'd5:    rcon = 32'h2000_0000;
			4'd6:    rcon = 32'h4000_0000;
			4'd7:    rcon = 32'h8000_0000;
			4'd8:    rcon = 32'h1B00_0000;
			4'd9:    rcon = 32'h3600_0000;
			default: rcon = 32'h0000_0000;
		endcase
	endfunction

endpackage

FILE: rtl/aeske_ctrl.sv
// Controller state machine for the key expansion: load, emit, handshakes.
module aeske_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  aeske_pkg::dp_stat_t  stat,
	output aeske_pkg::ctrl_cmd_t cmd
);

	aeske_pkg::state_t state_q, state_d;
	logic out_take;

	assign out_take = (state_q == aeske_pkg::ST_EMIT) && m_tready;
	assign m_tvalid = (state_q == aeske_pkg::ST_EMIT);
	// take a new key when idle, or in the cycle the last word leaves
	assign s_tready = (state_q == aeske_pkg::ST_IDLE) || (out_take && stat.last);

	always_comb begin
		cmd.load    = s_tvalid && s_tready;
		cmd.advance = out_take && !stat.last;
		state_d     = state_q;
		case (state_q)
			aeske_pkg::ST_IDLE: begin
				if (cmd.load) state_d = aeske_pkg::ST_EMIT;
			end
			aeske_pkg::ST_EMIT: begin
				if (out_take && stat.last && !cmd.load) state_d = aeske_pkg::ST_IDLE;
			end
			default: state_d = aeske_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aeske_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/aeske_dp.sv
// Datapath: four-word schedule window, word counter and round function.
module aeske_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [63:0]                        key_high,
	input  logic [63:0]                        key_low,
	input  aeske_pkg::ctrl_cmd_t               cmd,
	output aeske_pkg::dp_stat_t                stat,
	output logic [aeske_pkg::IdxW-1:0]         word_index,
	output aeske_pkg::word_t                   round_word
);

	aeske_pkg::word_t win_q [aeske_pkg::KeyWords];
	logic [aeske_pkg::IdxW-1:0] idx_q;
	aeske_pkg::word_t temp, next_word;

	// the word entering the window has index idx_q + 4
	always_comb begin
		temp = win_q[3];
		if (idx_q[1:0] == 2'b00)
			temp = aeske_pkg::sub_word(aeske_pkg::rot_word(win_q[3]))
			       ^ aeske_pkg::rcon(idx_q[5:2]);
		next_word = temp ^ win_q[0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[0] <= key_high[63:32];
			win_q[1] <= key_high[31:0];
			win_q[2] <= key_low[63:32];
			win_q[3] <= key_low[31:0];
		end else if (cmd.advance) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.advance) begin
			idx_q <= idx_q + aeske_pkg::IdxW'(1);
		end
	end

	assign stat.last  = (idx_q == aeske_pkg::LastIdx);
	assign word_index = idx_q;
	assign round_word = win_q[0];

endmodule

FILE: rtl/aes128_key_expansion.sv
// Top level of the AES-128 key expansion block.
//
// Usage: present one 128-bit cipher key on the slave stream (s_tdata holds
// key_high in bits 63:0 and key_low in bits 127:64). The block answers with
// the 44 words of the key schedule on the master stream, in order, each
// carrying its index in m_tdata[5:0] and the word in m_tdata[37:6]; m_tlast
// marks word 43.
// Latency: word 0 is valid in the cycle after the key is accepted.
// Throughput: one word per cycle while m_tready is high. The next key can be
// taken in the same cycle that word 43 leaves.
// Each new word comes from a four-word window register and one round
// function (rotate, four S-box lookups, round constant, xor) per cycle.
// Reset: clears the controller to idle and the word counter; s_tready is
// high after reset and m_tvalid is low.
// Stall: while a word is valid and m_tready is low, the current word, its index
// and m_tlast hold, and no new key is taken.
module aes128_key_expansion (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key_high [63:0], key_low [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // word_index [5:0], round_word [37:6], zero [39:38]
	output logic         m_tlast
);

	aeske_pkg::ctrl_cmd_t       cmd;
	aeske_pkg::dp_stat_t        stat;
	logic [aeske_pkg::IdxW-1:0] word_index;
	aeske_pkg::word_t           round_word;

	// sequence load and emit, drive the handshakes
	aeske_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold the window and advance it one word per taken item
	aeske_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_high   (s_tdata[63:0]),
		.key_low    (s_tdata[127:64]),
		.cmd        (cmd),
		.stat       (stat),
		.word_index (word_index),
		.round_word (round_word)
	);

	assign m_tdata = {2'b00, round_word, word_index};
	assign m_tlast = stat.last;

endmodule

FILE: rtl/aeske_chk.sv
// Port-level checker for the key expansion block, bound to the top level.
module aeske_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [39:0]  m_tdata,
	input logic         m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	// a schedule starts at word 0 after a key is taken
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid && m_tdata[5:0] == 6'd0)
		else $error("schedule did not start at word 0");

	// words follow one another without gaps inside a schedule
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[5:0] == 6'($past(m_tdata[5:0]) + 6'd1))
		else $error("word index did not step by one");

	// last flag marks word 43 only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[5:0] == aeske_pkg::LastIdx)))
		else $error("last flag does not match word 43");

	// a key is taken during a schedule only as its last word leaves
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tready && m_tlast)
		else $error("key taken in mid schedule");

endmodule

bind aes128_key_expansion aeske_chk u_aeske_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: bench/aes128_key_expansion_test.sv
// Self-checking testbench for the AES-128 key expansion block: directed and random keys.
module aes128_key_expansion_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Total keys to send: directed rows first, then random keys.
	localparam int     KeyCount   = 460;
	localparam int     NumRows    = 15;
	// Receiver hold-off used to back the block up into its input.
	localparam int     LongHold   = 400;
	localparam int     ReportMax  = 10;
	// Worst case is roughly 460 keys x 44 words x the longest random stall; allow a few times that.
	localparam longint CycleLimit = 8_000_000;

	// One directed stimulus row. When has_ref is set, words 4 and 43 of the schedule
	// are the published values for that key, typed in rather than predicted.
	typedef struct packed {
		logic [63:0]      key_hi;
		logic [63:0]      key_lo;
		logic             has_ref;
		aeske_pkg::word_t ref_w4;
		aeske_pkg::word_t ref_w43;
	} key_row_t;

	// One schedule word as the output stream should carry it.
	typedef struct packed {
		logic [aeske_pkg::IdxW-1:0] idx;
		aeske_pkg::word_t           word;
		logic                       last;
	} sched_word_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;   // key_high [63:0], key_low [127:64]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;         // word_index [5:0], round_word [37:6], zero [39:38]
	logic         m_tlast;

	// quiet: no gaps on either side; hold_req: ask the receiver for one long hold-off.
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	int fail_cnt = 0;

	logic [7:0]  sbox_lut [256];
	sched_word_t sched_q [$];

	// Zero, all ones, single bits at both ends, alternating patterns, half-and-half keys,
	// plus the two key vectors from the standard with their first and last derived words.
	key_row_t key_rows [NumRows] = '{
		'{64'h0000000000000000, 64'h0000000000000000, 1'b1, 32'h62636363, 32'h6f8f188e},
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1, 32'ha0fafe17, 32'hb6630ca6},
		'{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1, 32'hd6aa74fd, 32'h4d2b30c5},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 32'h0, 32'h0},
		'{64'h8000000000000000, 64'h0000000000000000, 1'b0, 32'h0, 32'h0},
		'{64'h0000000000000000, 64'h0000000000000001, 1'b0, 32'h0, 32'h0},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 32'h0, 32'h0},
		'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 32'h0, 32'h0},
		'{64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 32'h0, 32'h0},
		'{64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 32'h0, 32'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 32'h0, 32'h0},
		'{64'h00000000ffffffff, 64'hffffffff00000000, 1'b0, 32'h0, 32'h0},
		'{64'h0000000100000002, 64'h0000000300000004, 1'b0, 32'h0, 32'h0},
		'{64'h8080808080808080, 64'h0101010101010101, 1'b0, 32'h0, 32'h0},
		'{64'h7fffffffffffffff, 64'hfffffffffffffffe, 1'b0, 32'h0, 32'h0}
	};

	aes128_key_expansion dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Multiply by x in GF(2^8) with the AES polynomial.
	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p ^= x;
			x = xtime(x);
		end
		return p;
	endfunction

	// Derive the S-box from first principles: field inverse, then the affine map.
	function automatic void build_sbox();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
			              {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endfunction

	// Expand one key into its 44 schedule words and queue them in output order.
	function automatic void queue_schedule(input key_row_t row);
		aeske_pkg::word_t w [aeske_pkg::SchedWords];
		aeske_pkg::word_t t;
		logic [7:0]       rc;
		sched_word_t      e;
		w[0] = row.key_hi[63:32];
		w[1] = row.key_hi[31:0];
		w[2] = row.key_lo[63:32];
		w[3] = row.key_lo[31:0];
		rc = 8'h01;
		for (int i = aeske_pkg::KeyWords; i < aeske_pkg::SchedWords; i++) begin
			t = w[i-1];
			if (i % aeske_pkg::KeyWords == 0) begin
				// rotate left one byte, substitute each byte, fold in the round constant
				t = {sbox_lut[t[23:16]], sbox_lut[t[15:8]], sbox_lut[t[7:0]], sbox_lut[t[31:24]]}
				    ^ {rc, 24'h000000};
				rc = xtime(rc);
			end
			w[i] = t ^ w[i-aeske_pkg::KeyWords];
		end
		if (row.has_ref) begin
			w[4]                       = row.ref_w4;
			w[aeske_pkg::SchedWords-1] = row.ref_w43;
		end
		for (int i = 0; i < aeske_pkg::SchedWords; i++) begin
			e.idx  = aeske_pkg::IdxW'(i);
			e.word = w[i];
			e.last = (i == aeske_pkg::SchedWords - 1);
			sched_q.push_back(e);
		end
	endfunction

	// Mostly back-to-back, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly fully random keys, with lone bits, lone holes, repeated bytes and sparse keys.
	function automatic key_row_t random_row();
		key_row_t     r;
		logic [127:0] k;
		k = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: k = 128'h1 << $urandom_range(0, 127);
			1: k = ~(128'h1 << $urandom_range(0, 127));
			2: k = {16{8'($urandom)}};
			3: k = k & {$urandom, $urandom, $urandom, $urandom};
			default: ;
		endcase
		r        = '0;
		r.key_hi = k[127:64];
		r.key_lo = k[63:0];
		return r;
	endfunction

	// Offer one key, hold it until the block takes it, then queue its schedule.
	// Called at a rising edge; returns at the edge where the key was accepted.
	task automatic send_key(input key_row_t row);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.key_lo, row.key_hi};
		do
			@(posedge clk);
		while (!s_tready);
		queue_schedule(row);
	endtask

	// Sender and sequencing of the run.
	initial begin
		build_sbox();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NumRows; r++)
			send_key(key_rows[r]);

		// Quiet stretches at the start and in the middle, one long receiver hold-off
		// partway through, random idling everywhere else.
		for (int n = 0; n < KeyCount - NumRows; n++) begin
			quiet = (n < 40) || (n >= 300 && n < 340);
			if (n == 120)
				hold_req = 1'b1;
			send_key(random_row());
		end
		s_tvalid <= 1'b0;
		quiet = 1'b1;

		// Drain every queued word, then give the block a few more cycles to misbehave.
		while (sched_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random runs of ready and stall, always ready in quiet stretches,
	// and one long hold-off on request while the sender keeps offering keys.
	initial begin
		int run;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 9) < 7);
				case ($urandom_range(0, 99)) inside
					[0:79]:  run = $urandom_range(1, 3);
					[80:96]: run = $urandom_range(4, 10);
					default: run = $urandom_range(20, 80);
				endcase
				repeat (run - 1) @(posedge clk);
			end
		end
	end

	// Output check: each accepted word against the oldest queued expectation.
	always @(posedge clk) begin
		sched_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sched_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= ReportMax)
					$display("unexpected word: idx %0d word %h last %b",
					         m_tdata[5:0], m_tdata[37:6], m_tlast);
			end else begin
				want = sched_q.pop_front();
				if (m_tdata[5:0] !== want.idx || m_tdata[37:6] !== want.word ||
				    m_tlast !== want.last || m_tdata[39:38] !== 2'b00) begin
					fail_cnt++;
					if (fail_cnt <= ReportMax)
						$display("mismatch: exp %0d %h %b, got %0d %h %b pad %b",
						         want.idx, want.word, want.last,
						         m_tdata[5:0], m_tdata[37:6], m_tlast, m_tdata[39:38]);
				end
			end
		end
	end

	// Watchdog: a hung handshake or missing words end the run here.
	initial begin
		longint cyc;
		cyc = 0;
		while (cyc < CycleLimit) begin
			@(posedge clk);
			cyc++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/aeske_pkg.sv
rtl/aeske_ctrl.sv
rtl/aeske_dp.sv
rtl/aes128_key_expansion.sv
rtl/aeske_chk.sv
bench/aes128_key_expansion_test.sv
